// ===== design/cdf_pkg.sv =====
// ---------------------------------------------------------------------------
// cdf_pkg: shared types and constants of the critically damped follower
// Wide arithmetic width, saturation helpers and configuration register codes.
// ---------------------------------------------------------------------------
package cdf_pkg;

    localparam int unsigned WIDE_W  = 64;
    localparam int unsigned MAG_W   = 63;
    localparam int unsigned REG_W   = 31;
    localparam int unsigned IDX_W   = 2;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [REG_W-1:0]         t_reg;
    typedef logic [IDX_W-1:0]         t_idx;

    localparam t_idx REG_SMOOTH_TIME = 2'd0;
    localparam t_idx REG_MAX_SPEED   = 2'd1;
    localparam t_idx REG_TIME_STEP   = 2'd2;

    localparam t_reg ST_FLOOR        = 31'd7;
    localparam t_reg SMOOTH_RESET    = 31'd65536;
    localparam t_reg MAX_SPEED_RESET = 31'h7FFF_FFFF;
    localparam t_reg TIME_STEP_RESET = 31'd655;

    localparam t_wide WMAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WIDE_W:0] WMAX_X = 65'sh0_3FFF_FFFF_FFFF_FFFF;

    function automatic t_wide sat_w(input logic signed [WIDE_W:0] v);
        t_wide r;
        if (v > WMAX_X) begin
            r = WMAX;
        end else if (v < -WMAX_X) begin
            r = -WMAX;
        end else begin
            r = v[WIDE_W-1:0];
        end
        return r;
    endfunction

    function automatic t_wide add_w(input t_wide a, input t_wide b);
        return sat_w({a[WIDE_W-1], a} + {b[WIDE_W-1], b});
    endfunction

    function automatic t_wide sub_w(input t_wide a, input t_wide b);
        return sat_w({a[WIDE_W-1], a} - {b[WIDE_W-1], b});
    endfunction

endpackage

// ===== design/cdf_mul.sv =====
// ---------------------------------------------------------------------------
// cdf_mul: bit-serial fixed-point multiplier
// Sign-magnitude shift-add, one multiplier bit per cycle, then the product is
// truncated by the fraction bits and saturated to the wide range.
// ---------------------------------------------------------------------------
module cdf_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cdf_pkg::t_wide i_a,
    input  cdf_pkg::t_wide i_b,
    output logic          o_done,
    output cdf_pkg::t_wide o_p
);

    localparam int MW = cdf_pkg::MAG_W;

    logic                   r_busy;
    logic                   r_fin;
    logic                   r_done;
    logic [5:0]             r_cnt;
    logic                   r_neg;
    logic [MW-1:0]          r_a;
    logic [MW-1:0]          r_b;
    logic [MW-1:0]          r_hi;
    logic [MW-1:0]          r_lo;
    cdf_pkg::t_wide         r_p;

    cdf_pkg::t_wide         abs_a;
    cdf_pkg::t_wide         abs_b;
    logic [MW:0]            sum;
    logic [2*MW-1:0]        prod;
    logic                   sat;
    cdf_pkg::t_wide         mag;

    always_comb begin
        abs_a = i_a[cdf_pkg::WIDE_W-1] ? -i_a : i_a;
        abs_b = i_b[cdf_pkg::WIDE_W-1] ? -i_b : i_b;
        sum   = {1'b0, r_hi} + (r_b[0] ? {1'b0, r_a} : '0);
        prod  = {r_hi, r_lo};
        sat   = |prod[2*MW-1:FRAC_BITS+62];
        mag   = sat ? cdf_pkg::WMAX : {2'b00, prod[FRAC_BITS+61 -: 62]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_a[cdf_pkg::WIDE_W-1] != i_b[cdf_pkg::WIDE_W-1];
                r_a    <= abs_a[MW-1:0];
                r_b    <= abs_b[MW-1:0];
                r_hi   <= '0;
                r_lo   <= '0;
            end else if (r_busy) begin
                r_hi  <= sum[MW:1];
                r_lo  <= {sum[0], r_lo[MW-1:1]};
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_p    <= r_neg ? -mag : mag;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

// ===== design/cdf_div.sv =====
// ---------------------------------------------------------------------------
// cdf_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, quotient and remainder.
// ---------------------------------------------------------------------------
module cdf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_rem;
    logic [63:0] r_quo;

    logic [63:0] shifted;
    logic [64:0] trial;

    always_comb begin
        shifted = {r_rem[62:0], r_num[63]};
        trial   = {1'b0, shifted} - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (!trial[64]) begin
                    r_rem <= trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== design/critically_damped_follower.sv =====
// ---------------------------------------------------------------------------
// critically_damped_follower: smooth-damp spring follower in fixed point
// Moves a value toward a target along a critically damped spring.
// ---------------------------------------------------------------------------
// Usage: a request on the input channel (i_valid/o_ready) carries the mode,
// the current value and the target. One result request follows on the output
// channel (o_valid/i_ready) with the new value, the new velocity and the
// overshoot flag. Configuration requests (i_cfg_valid/o_cfg_ready) write
// smooth time, max speed or time step by index; an index of 3 is ignored.
// Each item in linear mode runs five multiplications on one bit-serial
// multiplier; angle mode adds one pass of the bit-serial divider for the
// angle wrap. No new item is taken until the block has finished the current
// one and is idle again.
// After reset and after each register write the block derives omega and the
// decay factor: two divisions and six multiplications, during which no
// request is taken on either input channel.
// The result sits in an output register; the next item is taken while it
// waits, and that item's result is held back until the receiver takes it.
// Reset restores the register defaults and clears the velocity.
// ---------------------------------------------------------------------------
module critically_damped_follower #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  cdf_pkg::t_idx                 i_cfg_index,
    input  cdf_pkg::t_reg                 i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic signed [VALUE_WIDTH-1:0] i_current_value,
    input  logic signed [VALUE_WIDTH-1:0] i_target_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [VALUE_WIDTH-1:0] o_next_value,
    output logic signed [VALUE_WIDTH-1:0] o_velocity_out,
    output logic                          o_overshoot_hit
);

    localparam cdf_pkg::t_wide ONE_Q  = 64'sd1 <<< FRAC_BITS;
    localparam cdf_pkg::t_wide C048   = 64'(((64'd48 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam cdf_pkg::t_wide C0235  = 64'(((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam cdf_pkg::t_wide DEG360 = 64'sd360 <<< FRAC_BITS;
    localparam cdf_pkg::t_wide DEG180 = 64'sd180 <<< FRAC_BITS;
    localparam logic [63:0] NUM_OMEGA = 64'd2 << (2 * FRAC_BITS);
    localparam logic [63:0] NUM_DECAY = 64'd1 << (2 * FRAC_BITS);
    localparam cdf_pkg::t_wide VMAX   =
        $signed(64'h7FFF_FFFF_FFFF_FFFF >> (64 - VALUE_WIDTH));
    localparam cdf_pkg::t_wide VMIN   = -VMAX - 64'sd1;

    typedef enum logic [4:0] {
        S_IDLE, S_OMEGA, S_X, S_X2, S_X3, S_C2, S_C3, S_MAXC, S_DECAY,
        S_WRAP, S_CHG, S_CLAMP, S_M1, S_M2, S_M3, S_M4, S_M5, S_DONE
    } t_state;

    t_state          r_state;
    logic            r_go;
    cdf_pkg::t_reg   r_smooth;
    cdf_pkg::t_reg   r_max;
    cdf_pkg::t_reg   r_ts;
    cdf_pkg::t_wide  r_vel;
    cdf_pkg::t_wide  r_omega;
    cdf_pkg::t_wide  r_x;
    cdf_pkg::t_wide  r_x2;
    cdf_pkg::t_wide  r_x3;
    cdf_pkg::t_wide  r_den;
    cdf_pkg::t_wide  r_maxc;
    cdf_pkg::t_wide  r_decay;
    cdf_pkg::t_wide  r_cur;
    cdf_pkg::t_wide  r_tgt;
    cdf_pkg::t_wide  r_chg;
    cdf_pkg::t_wide  r_base;
    cdf_pkg::t_wide  r_s;
    cdf_pkg::t_wide  r_temp;
    cdf_pkg::t_wide  r_u;
    cdf_pkg::t_wide  r_vnew;
    cdf_pkg::t_wide  r_res;
    logic            r_o_valid;
    logic signed [VALUE_WIDTH-1:0] r_o_next;
    logic signed [VALUE_WIDTH-1:0] r_o_vel;
    logic            r_o_hit;

    logic            mul_start;
    logic            mul_done;
    cdf_pkg::t_wide  mul_a;
    cdf_pkg::t_wide  mul_b;
    cdf_pkg::t_wide  mul_p;
    logic            div_start;
    logic            div_done;
    logic [63:0]     div_num;
    logic [63:0]     div_den;
    logic [63:0]     div_quo;
    logic [63:0]     div_rem;

    cdf_pkg::t_reg   st_eff;
    cdf_pkg::t_wide  cur_ext;
    cdf_pkg::t_wide  tgt_ext;
    cdf_pkg::t_wide  diff;
    cdf_pkg::t_wide  wrap_r;
    cdf_pkg::t_wide  clamped;
    logic            hit;
    cdf_pkg::t_wide  res_sel;
    cdf_pkg::t_wide  vel_sel;
    cdf_pkg::t_wide  res_sat;
    cdf_pkg::t_wide  vel_sat;
    logic            in_acc;
    logic            cfg_acc;
    logic            out_load;

    cdf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    cdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_comb begin
        st_eff  = (r_smooth < cdf_pkg::ST_FLOOR) ? cdf_pkg::ST_FLOOR : r_smooth;
        cur_ext = cdf_pkg::sat_w(65'(i_current_value));
        tgt_ext = cdf_pkg::sat_w(65'(i_target_value));
        diff    = r_tgt - r_cur;

        // C remainder takes the sign of the dividend; then fold into (-180,180].
        wrap_r = diff[63] ? -cdf_pkg::t_wide'(div_rem) : cdf_pkg::t_wide'(div_rem);
        if (wrap_r < 0) begin
            wrap_r = wrap_r + DEG360;
        end
        if (wrap_r > DEG180) begin
            wrap_r = wrap_r - DEG360;
        end

        if (r_chg > r_maxc) begin
            clamped = r_maxc;
        end else if (r_chg < -r_maxc) begin
            clamped = -r_maxc;
        end else begin
            clamped = r_chg;
        end

        hit     = (diff > 0) == (r_res > r_tgt);
        res_sel = hit ? r_tgt : r_res;
        vel_sel = hit ? '0 : r_vnew;
        res_sat = (res_sel > VMAX) ? VMAX : ((res_sel < VMIN) ? VMIN : res_sel);
        vel_sat = (vel_sel > VMAX) ? VMAX : ((vel_sel < VMIN) ? VMIN : vel_sel);

        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        unique case (r_state)
            S_OMEGA: begin
                div_num = NUM_OMEGA;
                div_den = 64'(st_eff);
            end
            S_X: begin
                mul_a = r_omega;
                mul_b = 64'(r_ts);
            end
            S_X2: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            S_X3: begin
                mul_a = r_x2;
                mul_b = r_x;
            end
            S_C2: begin
                mul_a = C048;
                mul_b = r_x2;
            end
            S_C3: begin
                mul_a = C0235;
                mul_b = r_x3;
            end
            S_MAXC: begin
                mul_a = 64'(r_max);
                mul_b = 64'(st_eff);
            end
            S_DECAY: begin
                div_num = NUM_DECAY;
                div_den = r_den;
            end
            S_WRAP: begin
                div_num = diff[63] ? -diff : diff;
                div_den = DEG360;
            end
            S_M1: begin
                mul_a = r_omega;
                mul_b = r_chg;
            end
            S_M2: begin
                mul_a = r_s;
                mul_b = 64'(r_ts);
            end
            S_M3: begin
                mul_a = r_omega;
                mul_b = r_temp;
            end
            S_M4: begin
                mul_a = r_s;
                mul_b = r_decay;
            end
            S_M5: begin
                mul_a = r_u;
                mul_b = r_decay;
            end
            default: begin
            end
        endcase

        mul_start = !r_go && (r_state == S_X || r_state == S_X2 || r_state == S_X3 ||
                    r_state == S_C2 || r_state == S_C3 || r_state == S_MAXC ||
                    r_state == S_M1 || r_state == S_M2 || r_state == S_M3 ||
                    r_state == S_M4 || r_state == S_M5);
        div_start = !r_go && (r_state == S_OMEGA || r_state == S_DECAY ||
                    r_state == S_WRAP);

        o_cfg_ready = (r_state == S_IDLE);
        o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
        in_acc      = i_valid && o_ready;
        cfg_acc     = i_cfg_valid && o_cfg_ready;
        out_load    = (r_state == S_DONE) && (!r_o_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_OMEGA;
            r_go      <= 1'b0;
            r_smooth  <= cdf_pkg::SMOOTH_RESET;
            r_max     <= cdf_pkg::MAX_SPEED_RESET;
            r_ts      <= cdf_pkg::TIME_STEP_RESET;
            r_vel     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (mul_start || div_start) begin
                r_go <= 1'b1;
            end
            if (mul_done || div_done) begin
                r_go <= 1'b0;
            end
            if (r_o_valid && i_ready && !out_load) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        unique case (i_cfg_index)
                            cdf_pkg::REG_SMOOTH_TIME: begin
                                r_smooth <= i_cfg_data;
                                r_state  <= S_OMEGA;
                            end
                            cdf_pkg::REG_MAX_SPEED: begin
                                r_max   <= i_cfg_data;
                                r_state <= S_OMEGA;
                            end
                            cdf_pkg::REG_TIME_STEP: begin
                                r_ts    <= i_cfg_data;
                                r_state <= S_OMEGA;
                            end
                            default: begin
                            end
                        endcase
                    end else if (in_acc) begin
                        r_cur   <= cur_ext;
                        r_tgt   <= tgt_ext;
                        r_state <= i_operation ? S_WRAP : S_CHG;
                    end
                end
                S_OMEGA: begin
                    if (div_done) begin
                        r_omega <= div_quo;
                        r_state <= S_X;
                    end
                end
                S_X: begin
                    if (mul_done) begin
                        r_x     <= mul_p;
                        r_den   <= cdf_pkg::add_w(ONE_Q, mul_p);
                        r_state <= S_X2;
                    end
                end
                S_X2: begin
                    if (mul_done) begin
                        r_x2    <= mul_p;
                        r_state <= S_X3;
                    end
                end
                S_X3: begin
                    if (mul_done) begin
                        r_x3    <= mul_p;
                        r_state <= S_C2;
                    end
                end
                S_C2: begin
                    if (mul_done) begin
                        r_den   <= cdf_pkg::add_w(r_den, mul_p);
                        r_state <= S_C3;
                    end
                end
                S_C3: begin
                    if (mul_done) begin
                        r_den   <= cdf_pkg::add_w(r_den, mul_p);
                        r_state <= S_MAXC;
                    end
                end
                S_MAXC: begin
                    if (mul_done) begin
                        r_maxc  <= mul_p;
                        r_state <= S_DECAY;
                    end
                end
                S_DECAY: begin
                    if (div_done) begin
                        r_decay <= div_quo;
                        r_state <= S_IDLE;
                    end
                end
                S_WRAP: begin
                    if (div_done) begin
                        r_tgt   <= cdf_pkg::add_w(r_cur, wrap_r);
                        r_state <= S_CHG;
                    end
                end
                S_CHG: begin
                    r_chg   <= cdf_pkg::sub_w(r_cur, r_tgt);
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_chg   <= clamped;
                    r_base  <= cdf_pkg::sub_w(r_cur, clamped);
                    r_state <= S_M1;
                end
                S_M1: begin
                    if (mul_done) begin
                        r_s     <= cdf_pkg::add_w(r_vel, mul_p);
                        r_state <= S_M2;
                    end
                end
                S_M2: begin
                    if (mul_done) begin
                        r_temp  <= mul_p;
                        r_u     <= cdf_pkg::add_w(r_chg, mul_p);
                        r_state <= S_M3;
                    end
                end
                S_M3: begin
                    if (mul_done) begin
                        r_s     <= cdf_pkg::sub_w(r_vel, mul_p);
                        r_state <= S_M4;
                    end
                end
                S_M4: begin
                    if (mul_done) begin
                        r_vnew  <= mul_p;
                        r_state <= S_M5;
                    end
                end
                S_M5: begin
                    if (mul_done) begin
                        r_res   <= cdf_pkg::add_w(r_base, mul_p);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // The velocity advances only when the result enters the output register.
                    if (out_load) begin
                        r_vel     <= vel_sat;
                        r_o_valid <= 1'b1;
                        r_o_next  <= res_sat[VALUE_WIDTH-1:0];
                        r_o_vel   <= vel_sat[VALUE_WIDTH-1:0];
                        r_o_hit   <= hit;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_o_valid;
    assign o_next_value    = r_o_next;
    assign o_velocity_out  = r_o_vel;
    assign o_overshoot_hit = r_o_hit;

`ifndef SYNTH
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready && !o_cfg_ready)
        else $error("input taken while an item is in progress");

    a_snap_clears_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overshoot_hit |-> o_velocity_out == '0)
        else $error("snapped result with non-zero velocity");

    a_cfg_derives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc && (i_cfg_index == cdf_pkg::REG_SMOOTH_TIME ||
                    i_cfg_index == cdf_pkg::REG_MAX_SPEED ||
                    i_cfg_index == cdf_pkg::REG_TIME_STEP) |=> !o_ready)
        else $error("register write did not start derivation");
`endif

endmodule
